/* rtl/rlcg_pkg.sv */
// shared types and constants for the ranged lcg random generator
package rlcg_pkg;

  // seed update constants
  localparam logic [31:0] LCG_MUL = 32'h0003_43FD;
  localparam logic [31:0] LCG_ADD = 32'h0026_9EC3;

  // range limit reset value
  localparam logic [30:0] LIMIT_RESET = 31'h7FFF_FFFF;

  // divider steps, one quotient bit each
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // operation codes
  typedef enum logic [1:0] {
    FUNC_RANGED = 2'd0,
    FUNC_RAW    = 2'd1,
    FUNC_SEED   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // command beat
  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;
    logic [31:0]        new_seed;
  } cmd_t;

  // result beat
  typedef struct packed {
    logic signed [31:0] ranged_value;
    logic [31:0]        raw_value;
    logic               range_error;
    logic               bounds_swapped;
  } res_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ADVANCE,
    ST_DIV,
    ST_FINISH
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic take;
    logic check;
    logic advance;
    logic div_step;
    logic load_out;
  } dp_ctrl_t;

  // datapath to controller status
  typedef struct packed {
    func_t op;
    logic  range_err;
  } dp_stat_t;

endpackage

/* rtl/rlcg_ctrl.sv */
// controller: sequences check, seed advance, modulo steps and result load
module rlcg_ctrl
  import rlcg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  input  func_t    cmd_func,
  output logic     cmd_stall,
  output logic     res_valid,
  input  logic     res_stall,
  input  dp_stat_t stat,
  output dp_ctrl_t ctrl
);

  state_t               state, state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 out_free;

  // output register can take a new result
  assign out_free = !res_valid || !res_stall;

  // state register and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      if (ctrl.advance) begin
        div_cnt <= '0;
      end else if (ctrl.div_step) begin
        div_cnt <= div_cnt + 1'b1;
      end
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    ctrl       = '0;
    cmd_stall  = 1'b1;
    unique case (state)
      ST_IDLE: begin
        cmd_stall = 1'b0;
        if (cmd_valid) begin
          ctrl.take = 1'b1;
          case (cmd_func)
            FUNC_RANGED: state_next = ST_CHECK;
            FUNC_RAW:    state_next = ST_ADVANCE;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_CHECK: begin
        ctrl.check = 1'b1;
        state_next = stat.range_err ? ST_FINISH : ST_ADVANCE;
      end
      ST_ADVANCE: begin
        ctrl.advance = 1'b1;
        state_next   = (stat.op == FUNC_RANGED) ? ST_DIV : ST_FINISH;
      end
      ST_DIV: begin
        ctrl.div_step = 1'b1;
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          ctrl.load_out = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* rtl/rlcg_dp.sv */
// datapath: seed, bound sorting, range check, restoring modulo, result register
module rlcg_dp
  import rlcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic        cfg_valid,
  input  logic [30:0] cfg_data,
  input  dp_ctrl_t    ctrl,
  output dp_stat_t    stat,
  output res_t        res
);

  logic [31:0]        seed;
  logic [30:0]        limit;
  func_t              op;
  logic signed [31:0] lo_r;
  logic signed [31:0] hi_r;
  logic               swapped;
  logic               err;
  logic [31:0]        divisor;
  logic [30:0]        rem;
  logic [31:0]        dq;

  logic [31:0]        seed_next;
  logic [32:0]        range_c;
  logic               range_err_c;
  logic [32:0]        trial;
  logic [30:0]        rem_next;
  logic [31:0]        sum_c;

  // lcg advance
  assign seed_next = seed * LCG_MUL + LCG_ADD;

  // exact 33-bit range of the sorted bounds
  assign range_c     = {hi_r[31], hi_r} - {lo_r[31], lo_r};
  assign range_err_c = range_c >= {2'b00, limit};

  // one restoring division step
  assign trial    = {1'b0, rem, dq[31]} - {1'b0, divisor};
  assign rem_next = trial[32] ? {rem[29:0], dq[31]} : trial[30:0];

  // lower bound plus remainder, wrapping
  assign sum_c = lo_r + {1'b0, rem};

  assign stat.op        = op;
  assign stat.range_err = range_err_c;

  // seed and range limit
  always_ff @(posedge clk) begin
    if (rst) begin
      seed  <= '0;
      limit <= LIMIT_RESET;
    end else begin
      if (cfg_valid) begin
        limit <= cfg_data;
      end
      if (ctrl.take && cmd.func == FUNC_SEED) begin
        seed <= cmd.new_seed;
      end else if (ctrl.advance) begin
        seed <= seed_next;
      end
    end
  end

  // operand capture, bound sort and modulo
  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      op  <= func_t'(cmd.func);
      err <= 1'b0;
      if (cmd.high_bound < cmd.low_bound) begin
        lo_r    <= cmd.high_bound;
        hi_r    <= cmd.low_bound;
        swapped <= 1'b1;
      end else begin
        lo_r    <= cmd.low_bound;
        hi_r    <= cmd.high_bound;
        swapped <= 1'b0;
      end
    end
    if (ctrl.check) begin
      err <= range_err_c;
    end
    if (ctrl.advance) begin
      dq      <= seed_next;
      rem     <= '0;
      divisor <= range_c[31:0] + 32'd1;
    end else if (ctrl.div_step) begin
      dq  <= {dq[30:0], 1'b0};
      rem <= rem_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      if (op == FUNC_RANGED) begin
        res.ranged_value   <= err ? 32'sd0 : $signed(sum_c);
        res.raw_value      <= '0;
        res.range_error    <= err;
        res.bounds_swapped <= swapped;
      end else begin
        res.ranged_value   <= 32'sd0;
        res.raw_value      <= seed;
        res.range_error    <= 1'b0;
        res.bounds_swapped <= 1'b0;
      end
    end
  end

endmodule

/* rtl/ranged_lcg_random.sv */
// ranged lcg random generator top level
//
// command channel (cmd_valid, cmd_stall, cmd) takes one beat with a func code:
// ranged draw, raw draw, or reseed. result channel (res_valid, res_stall, res)
// gives one beat per ranged or raw draw; reseed and the unused code give none.
// the range_limit register is written through cfg_valid / cfg_ready / cfg_data.
// the user must write it only while the block is idle; the block itself does
// not enforce this. cfg_ready is always high. one command is worked on at a
// time. a raw draw passes the advance and finish states; a ranged draw passes
// check, advance, the 32-step restoring modulo unit (one quotient bit per
// cycle) and finish; a ranged draw that fails the range check goes from check
// straight to finish. the next command can be taken in the cycle after the
// result loads; a reseed leaves the controller idle for the next command.
// a finished result sits in the output register; the next command is taken
// while it waits, and a later result holds in the controller until the
// receiver stops stalling.
// synchronous reset clears the seed to zero, sets range_limit to its maximum
// and drops res_valid.
module ranged_lcg_random
  import rlcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  cmd_t        cmd,
  output logic        res_valid,
  input  logic        res_stall,
  output res_t        res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_data
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  // controller
  rlcg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_func  (func_t'(cmd.func)),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // datapath
  rlcg_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .stat      (stat),
    .res       (res)
  );

endmodule

/* rtl/rlcg_checker.sv */
// port-level checks for the ranged lcg random generator, bound to the top level
module rlcg_checker
  import rlcg_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_stall,
  input cmd_t        cmd,
  input logic        res_valid,
  input logic        res_stall,
  input res_t        res,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [30:0] cfg_data
);

  // stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result beat changed");

  // a draw keeps the command side busy in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && (cmd.func == FUNC_RANGED || cmd.func == FUNC_RAW)
    |=> cmd_stall)
    else $error("draw accepted without busy period");

  // an error result carries zero values
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.range_error |-> res.ranged_value == 0 && res.raw_value == 0)
    else $error("range error beat with nonzero value");

  // a raw beat carries no ranged flags
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.raw_value != 0 |->
    !res.range_error && !res.bounds_swapped && res.ranged_value == 0)
    else $error("raw beat with ranged fields set");

  // reset empties the result register
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind ranged_lcg_random rlcg_checker u_rlcg_checker (.*);

/* dv/testbench.sv */
`timescale 1ns / 1ps
// testbench for the ranged lcg random generator: directed and random draws
module testbench;
  import rlcg_pkg::*;

  // cycles the block may still be busy on a beat that gives no result
  localparam int DRAIN_CYCLES = 40;
  localparam int DRAIN_GUARD  = 20000;

  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

  typedef enum int {
    STALL_OFF,
    STALL_HOLD,
    STALL_RANDOM
  } stall_mode_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  cmd_t        cmd       = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  res_t        res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [30:0] cfg_data  = '0;

  // expected draw results, oldest first
  res_t        pending_draws[$];
  // predicted generator state and limit register
  logic [31:0] shadow_seed  = '0;
  logic [30:0] shadow_limit = LIMIT_RESET;

  int          fail_count = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  stall_mode_t stall_mode = STALL_OFF;

  ranged_lcg_random dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // predict one command beat; returns 1 when it yields a result beat
  function automatic bit predict_draw(input cmd_t c, output res_t r);
    logic signed [32:0] lo;
    logic signed [32:0] hi;
    logic signed [32:0] tmp;
    logic [32:0]        span;
    logic [31:0]        offset;
    r = '0;
    predict_draw = 1'b0;
    case (c.func)
      FUNC_RANGED: begin
        lo = $signed(c.low_bound);
        hi = $signed(c.high_bound);
        if (hi < lo) begin
          tmp = lo;
          lo  = hi;
          hi  = tmp;
          r.bounds_swapped = 1'b1;
        end
        // exact 33-bit spread, never wrapped
        span = hi - lo;
        if (span >= {2'b00, shadow_limit}) begin
          r.range_error = 1'b1;
        end else begin
          shadow_seed = shadow_seed * LCG_MUL + LCG_ADD;
          offset = shadow_seed % (span[31:0] + 32'd1);
          r.ranged_value = lo[31:0] + offset;
        end
        predict_draw = 1'b1;
      end
      FUNC_RAW: begin
        shadow_seed = shadow_seed * LCG_MUL + LCG_ADD;
        r.raw_value = shadow_seed;
        predict_draw = 1'b1;
      end
      FUNC_SEED: begin
        shadow_seed = c.new_seed;
      end
      default: begin
      end
    endcase
  endfunction

  // command with the given func and random contents in every other field
  function automatic cmd_t noise_cmd(input func_t f);
    cmd_t c;
    c.func       = f;
    c.low_bound  = $urandom;
    c.high_bound = $urandom;
    c.new_seed   = $urandom;
    return c;
  endfunction

  function automatic cmd_t ranged_cmd(input logic signed [31:0] lo,
                                      input logic signed [31:0] hi);
    cmd_t c;
    c = noise_cmd(FUNC_RANGED);
    c.low_bound  = lo;
    c.high_bound = hi;
    return c;
  endfunction

  function automatic cmd_t seed_cmd(input logic [31:0] value);
    cmd_t c;
    c = noise_cmd(FUNC_SEED);
    c.new_seed = value;
    return c;
  endfunction

  function automatic logic signed [31:0] corner_value();
    case ($urandom_range(0, 4))
      0:       return INT_MIN;
      1:       return INT_MAX;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  // random beat, mostly ranged draws; some of their spans lie around the current limit
  function automatic cmd_t random_cmd();
    cmd_t               c;
    int                 pick;
    longint             span;
    longint             room;
    longint             base;
    longint             top;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    pick = $urandom_range(0, 99);
    if (pick >= 95) return noise_cmd(FUNC_NONE);
    if (pick >= 85) return noise_cmd(FUNC_SEED);
    if (pick >= 65) return noise_cmd(FUNC_RAW);
    c = noise_cmd(FUNC_RANGED);
    case ($urandom_range(0, 4))
      3: return c;
      4: begin
        lo = corner_value();
        hi = corner_value();
      end
      default: begin
        case ($urandom_range(0, 2))
          0:       span = $urandom_range(0, 255);
          1:       span = $urandom_range(0, 1 << 20);
          default: span = longint'(shadow_limit) + $urandom_range(0, 2) - 1;
        endcase
        if (span < 0) span = 0;
        // place the span anywhere in the signed 32-bit range
        room = 64'sh0_FFFF_FFFF - span;
        base = (longint'($urandom) % (room + 1)) - 64'sd2147483648;
        top  = base + span;
        lo   = base[31:0];
        hi   = top[31:0];
      end
    endcase
    if ($urandom_range(0, 1) == 1) begin
      c.low_bound  = hi;
      c.high_bound = lo;
    end else begin
      c.low_bound  = lo;
      c.high_bound = hi;
    end
    return c;
  endfunction

  // send one command beat, then maybe a gap between bursts
  task automatic send_cmd(input cmd_t c);
    res_t expected;
    int   gap;
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    if (predict_draw(c, expected)) pending_draws.push_back(expected);
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 45);
    end else begin
      burst_left--;
    end
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait for all results plus the block's own latency
  task automatic wait_idle();
    int guard;
    cmd_valid <= 1'b0;
    guard = 0;
    while (pending_draws.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_range_limit(input logic [30:0] value);
    wait_idle();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    shadow_limit = value;
    cfg_valid <= 1'b0;
  endtask

  // state and limit right after reset, unused code, reseed
  task automatic test_after_reset();
    send_cmd(noise_cmd(FUNC_RAW));
    send_cmd(ranged_cmd(32'sd0, 32'sd0));
    send_cmd(ranged_cmd(32'shC000_0000, 32'sh3FFF_FFFE));
    send_cmd(ranged_cmd(32'shC000_0000, 32'sh3FFF_FFFF));
    send_cmd(ranged_cmd(INT_MAX, INT_MIN));
    send_cmd(noise_cmd(FUNC_NONE));
    send_cmd(seed_cmd(32'h1234_5678));
    send_cmd(noise_cmd(FUNC_RAW));
  endtask

  // bound extremes, reversed bounds, seed extremes
  task automatic test_bound_extremes();
    send_cmd(ranged_cmd(INT_MIN, INT_MIN));
    send_cmd(ranged_cmd(INT_MAX, INT_MAX));
    send_cmd(ranged_cmd(INT_MIN, INT_MIN + 32'sd5));
    send_cmd(ranged_cmd(32'sd100, -32'sd100));
    send_cmd(ranged_cmd(INT_MIN, INT_MAX));
    send_cmd(seed_cmd(32'hFFFF_FFFF));
    send_cmd(noise_cmd(FUNC_RAW));
    send_cmd(seed_cmd(32'h0000_0000));
    send_cmd(ranged_cmd(-32'sd1, 32'sd1));
  endtask

  // smallest limits, zero limit and a limit at a small span
  task automatic test_limit_settings();
    set_range_limit(31'd1);
    send_cmd(ranged_cmd(32'sd5, 32'sd5));
    send_cmd(ranged_cmd(32'sd5, 32'sd6));
    send_cmd(ranged_cmd(32'sd6, 32'sd5));
    set_range_limit(31'd0);
    send_cmd(ranged_cmd(32'sd3, 32'sd3));
    send_cmd(noise_cmd(FUNC_RAW));
    set_range_limit(31'd16);
    send_cmd(ranged_cmd(-32'sd8, 32'sd7));
    send_cmd(ranged_cmd(-32'sd8, 32'sd8));
  endtask

  // random beats under one limit setting
  task automatic test_random_draws(input int count, input logic [30:0] limit);
    cmd_t c;
    int   sent;
    set_range_limit(limit);
    sent = 0;
    while (sent < count) begin
      c = random_cmd();
      send_cmd(c);
      if (c.func != FUNC_NONE) sent++;
    end
  endtask

  // receiver stall pattern: clear, held and random stretches
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      stall_left = (stall_mode == STALL_HOLD) ? $urandom_range(1, 30) : $urandom_range(1, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_OFF:  res_stall <= 1'b0;
      STALL_HOLD: res_stall <= 1'b1;
      default:    res_stall <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // compare each result beat with the oldest expected draw
  always @(posedge clk) begin : check_beat
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_draws.size() == 0) begin
        $error("result beat with no draw expected");
        fail_count++;
      end else begin
        want = pending_draws.pop_front();
        if (res.ranged_value !== want.ranged_value) begin
          $error("ranged_value: expected %0d, actual %0d", want.ranged_value, res.ranged_value);
          fail_count++;
        end
        if (res.raw_value !== want.raw_value) begin
          $error("raw_value: expected %h, actual %h", want.raw_value, res.raw_value);
          fail_count++;
        end
        if (res.range_error !== want.range_error) begin
          $error("range_error: expected %b, actual %b", want.range_error, res.range_error);
          fail_count++;
        end
        if (res.bounds_swapped !== want.bounds_swapped) begin
          $error("bounds_swapped: expected %b, actual %b",
                 want.bounds_swapped, res.bounds_swapped);
          fail_count++;
        end
      end
    end
  end

  // run limit
  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_after_reset();
    test_bound_extremes();
    test_limit_settings();
    test_random_draws(500, LIMIT_RESET);
    test_random_draws(400, 31'($urandom_range(1, 32'h7FFF_FFFF)));
    test_random_draws(400, 31'($urandom_range(1, 4096)));
    test_random_draws(300, 31'd1);
    test_random_draws(400, 31'($urandom_range(1, 32'h7FFF_FFFF)));
    wait_idle();
    if (pending_draws.size() != 0) begin
      $error("%0d expected results never arrived", pending_draws.size());
    end
    if (fail_count == 0 && pending_draws.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
